### sv/tpa_pkg.sv
`default_nettype none

package tpa_pkg;

  localparam int NUM_TIMERS = 5;
  localparam int COUNT_W    = 16;
  localparam int ID_W       = 8;
  localparam int OP_W       = 3;

  // Slot index width and fill counter width (the counter must hold NUM_TIMERS itself).
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  localparam logic [ID_W-1:0] NO_SLOT = '1;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_START  = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
  localparam logic [OP_W-1:0] OP_STATUS = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [ID_W-1:0]    timer_id;
    logic [COUNT_W-1:0] load_value;
    logic [COUNT_W-1:0] tick_period;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0] allocated_id;
    logic            running;
  } response_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               nonzero;
  } alu_out_t;

endpackage

`default_nettype wire

### sv/tpa_ram.sv
`default_nettype none

module tpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/tpa_alu.sv
`default_nettype none

module tpa_alu (
  input  logic                        valid,
  input  logic [tpa_pkg::COUNT_W-1:0] count,
  input  logic [tpa_pkg::COUNT_W-1:0] period,
  output tpa_pkg::alu_out_t           result
);
  import tpa_pkg::*;

  logic [COUNT_W-1:0] operand;
  logic [COUNT_W:0]   diff;

  // A slot that was never loaded, or was stopped, holds zero.
  assign operand = valid ? count : '0;
  assign diff    = {1'b0, operand} - {1'b0, period};

  always_comb begin
    result.count   = diff[COUNT_W] ? '0 : diff[COUNT_W-1:0];
    result.nonzero = (operand != '0);
  end

endmodule

`default_nettype wire

### sv/timer_pool_allocator.sv
`default_nettype none

// Pool of NUM_TIMERS 16-bit down-counting timers. A command is transferred when start is high
// and busy is low; its single result appears on response for exactly one cycle with done high,
// and the receiver cannot hold it off. Create, start, stop, unused codes, out-of-range status
// queries and a tick with no allocated slot end with done high in the cycle after the transfer.
// A status query on a valid slot first passes through the status state because the count RAM
// has a registered read. A tick visits each allocated slot in the tick state: a single
// subtractor walks the count RAM one slot per cycle, reading the next slot while writing back
// the current one. Slots are handed out in order and never freed, so allocation is a fill
// count; counts reset through per-slot valid bits, so no clearing pass is needed after reset.
module timer_pool_allocator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tpa_pkg::request_t  request,
  output logic               done,
  output tpa_pkg::response_t response
);
  import tpa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_STATUS = 3'b010,
    ST_TICK   = 3'b100
  } state_t;

  state_t                state, state_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [CNT_W-1:0]      fill, fill_next;
  logic [NUM_TIMERS-1:0] valid, valid_next;
  logic [COUNT_W-1:0]    period, period_next;
  logic                  done_next;
  response_t             response_next;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [COUNT_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [COUNT_W-1:0]    ram_rdata;
  alu_out_t              alu;

  logic                  accept;
  logic                  in_range;
  logic [IDX_W-1:0]      req_idx;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (request.timer_id < ID_W'(NUM_TIMERS));
  assign req_idx  = request.timer_id[IDX_W-1:0];

  tpa_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(NUM_TIMERS)
  ) u_count_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tpa_alu u_alu (
    .valid (valid[idx]),
    .count (ram_rdata),
    .period(period),
    .result(alu)
  );

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    fill_next     = fill;
    valid_next    = valid;
    period_next   = period;
    done_next     = 1'b0;
    response_next = '{allocated_id: NO_SLOT, running: 1'b0};
    ram_we        = 1'b0;
    ram_waddr     = idx;
    ram_wdata     = alu.count;
    ram_raddr     = idx;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (request.operation)
            OP_CREATE: begin
              done_next = 1'b1;
              if (fill != CNT_W'(NUM_TIMERS)) begin
                response_next.allocated_id = ID_W'(fill);
                fill_next                  = fill + 1'b1;
              end
            end
            OP_START: begin
              done_next = 1'b1;
              if (in_range) begin
                ram_we              = 1'b1;
                ram_waddr           = req_idx;
                ram_wdata           = request.load_value;
                valid_next[req_idx] = 1'b1;
              end
            end
            OP_STOP: begin
              done_next = 1'b1;
              if (in_range) begin
                valid_next[req_idx] = 1'b0;
              end
            end
            OP_TICK: begin
              if (fill == '0) begin
                done_next = 1'b1;
              end else begin
                idx_next    = '0;
                ram_raddr   = '0;
                period_next = request.tick_period;
                state_next  = ST_TICK;
              end
            end
            OP_STATUS: begin
              if (in_range) begin
                idx_next   = req_idx;
                ram_raddr  = req_idx;
                state_next = ST_STATUS;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_STATUS: begin
        done_next             = 1'b1;
        response_next.running = alu.nonzero;
        state_next            = ST_IDLE;
      end
      ST_TICK: begin
        // Write back the current slot while the next one is being read.
        ram_we          = 1'b1;
        valid_next[idx] = 1'b1;
        if (CNT_W'(idx) + 1'b1 == fill) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          idx_next  = idx + 1'b1;
          ram_raddr = idx + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      fill  <= '0;
      valid <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      fill  <= fill_next;
      valid <= valid_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    period   <= period_next;
    response <= response_next;
  end

endmodule

`default_nettype wire

### sv/tpa_checker.sv
`default_nettype none

module tpa_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input tpa_pkg::request_t  request,
  input logic               done,
  input tpa_pkg::response_t response
);
  import tpa_pkg::*;

  // Every result follows a transfer in the previous cycle or the end of a multi-cycle command.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a pending command");

  // The result cycle always finds the block ready for the next command.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high in the result cycle");

  // Busy only rises on a transfer.
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // A slot index is only given by create, and never with a running status.
  a_id_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (response.allocated_id == NO_SLOT) ||
             ((response.allocated_id < ID_W'(NUM_TIMERS)) && !response.running))
    else $error("bad allocated slot index");

endmodule

bind timer_pool_allocator tpa_checker u_tpa_checker (.*);

`default_nettype wire
